// ----- sv/playfair_cipher_engine_core_macros.svh -----
// Assertion macros for the Playfair engine.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef PLAYFAIR_CIPHER_ENGINE_CORE_MACROS_SVH
`define PLAYFAIR_CIPHER_ENGINE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Plain property, checked outside reset
`define PFC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication, checked outside reset
`define PFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define PFC_ASSERT(lbl, clk, rst_n, prop, msg)
`define PFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- sv/pfc_pkg.sv -----
// Shared types, codes and square geometry helpers for the Playfair engine.
// No dependencies; used by pfc_geom and playfair_cipher_engine_core.
`timescale 1ns / 1ps

package pfc_pkg;

    localparam int SIDE     = 5;
    localparam int CELLS    = 25;
    localparam int NLETTERS = 26;

    typedef logic [4:0] t_letter;
    typedef logic [4:0] t_pos;
    typedef logic [2:0] t_rc;

    // Input actions
    localparam logic [1:0] ACT_KEY     = 2'd0;
    localparam logic [1:0] ACT_KEY_END = 2'd1;
    localparam logic [1:0] ACT_MSG     = 2'd2;
    localparam logic [1:0] ACT_MSG_END = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_LETTER  = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_END_ODD = 2'd2;

    // Letters with special handling
    localparam t_letter LETTER_I   = 5'd8;
    localparam t_letter LETTER_J   = 5'd9;
    localparam t_letter LETTER_X   = 5'd23;
    localparam t_letter LETTER_Z   = 5'd25;
    localparam t_letter LETTER_MAX = 5'd25;

    typedef struct packed {
        logic [1:0] action;
        t_letter    letter;
    } t_in_item;

    typedef struct packed {
        t_letter    letter_out;
        logic [1:0] kind;
        logic       last;
    } t_out_item;

    // Row of a square position: p*13 >> 6 equals p / 5 for p below 25
    function automatic t_rc pos_row(input t_pos p);
        logic [9:0] prod;
        prod = 10'(p) * 10'd13;
        return prod[8:6];
    endfunction

    function automatic t_pos rc_addr(input t_rc row, input t_rc col);
        return 5'({row, 2'b00}) + 5'(row) + 5'(col);
    endfunction

    function automatic t_rc pos_col(input t_pos p);
        t_pos base;
        base = rc_addr(pos_row(p), 3'd0);
        return 3'(p - base);
    endfunction

    // One step along a row or column, wrapping modulo the side
    function automatic t_rc rc_step(input t_rc v, input logic dec);
        t_rc res;
        if (dec) begin
            res = (v == 3'd0) ? 3'(SIDE - 1) : v - 3'd1;
        end else begin
            res = (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
        end
        return res;
    endfunction

endpackage

// ----- sv/pfc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the key square and the letter position table.
`timescale 1ns / 1ps

module pfc_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 25
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write first port, read returns the old contents on a collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/pfc_geom.sv -----
// Playfair pair geometry: maps the square positions of a pair to the
// square addresses of the two output letters. Depends on pfc_pkg.
`timescale 1ns / 1ps

module pfc_geom
    import pfc_pkg::*;
(
    input  t_pos i_pos_a,
    input  t_pos i_pos_b,
    input  logic i_dec,
    output t_pos o_addr1,
    output t_pos o_addr2
);

    t_rc w_ra, w_ca, w_rb, w_cb;

    always_comb begin
        w_ra = pos_row(i_pos_a);
        w_ca = pos_col(i_pos_a);
        w_rb = pos_row(i_pos_b);
        w_cb = pos_col(i_pos_b);
    end

    // Same column shifts vertically, same row horizontally, else swap columns
    always_comb begin
        priority if (w_ca == w_cb) begin
            o_addr1 = rc_addr(rc_step(w_ra, i_dec), w_ca);
            o_addr2 = rc_addr(rc_step(w_rb, i_dec), w_cb);
        end else if (w_ra == w_rb) begin
            o_addr1 = rc_addr(w_ra, rc_step(w_ca, i_dec));
            o_addr2 = rc_addr(w_rb, rc_step(w_cb, i_dec));
        end else begin
            o_addr1 = rc_addr(w_ra, w_cb);
            o_addr2 = rc_addr(w_rb, w_ca);
        end
    end

endmodule

// ----- sv/playfair_cipher_engine_core.sv -----
// Playfair cipher engine: key square build, digraph preparation and pairing.
// A key letter is placed in the cycle it is accepted; a message letter passes the fill
// state and is held or paired; a pair steps through RDA, RDB, CALC, SQ1, SQ2, EMIT1 and
// EMIT2, an end marker through MARK. The first key end or message action adds a fill
// sweep, one alphabet letter per cycle. One item in flight: a pair blocks the next
// transfer until emitted. Reset (synchronous, active low) clears the key state.
`timescale 1ns / 1ps
`include "playfair_cipher_engine_core_macros.svh"

module playfair_cipher_engine_core
    import pfc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_FILL  = 10'b00_0000_0010,
        S_RDA   = 10'b00_0000_0100,
        S_RDB   = 10'b00_0000_1000,
        S_CALC  = 10'b00_0001_0000,
        S_SQ1   = 10'b00_0010_0000,
        S_SQ2   = 10'b00_0100_0000,
        S_EMIT1 = 10'b00_1000_0000,
        S_EMIT2 = 10'b01_0000_0000,
        S_MARK  = 10'b10_0000_0000
    } t_state;

    // Control registers
    t_state            r_state, n_state;
    logic              r_mode;
    logic [NLETTERS-1:0] r_used, n_used;
    logic [4:0]        r_fill, n_fill;
    logic              r_complete, n_complete;
    t_letter           r_scan, n_scan;
    logic              r_held_valid, n_held_valid;
    logic              r_out_valid, n_out_valid;

    // Payload registers
    t_letter    r_held, n_held;
    logic [1:0] r_act, n_act;
    t_letter    r_letter, n_letter;
    t_letter    r_a, n_a;
    t_letter    r_b, n_b;
    logic       r_dec, n_dec;
    logic       r_tail, n_tail;
    logic [1:0] r_kind, n_kind;
    t_pos       r_pa, n_pa;
    t_pos       r_addr1, n_addr1;
    t_pos       r_addr2, n_addr2;
    t_letter    r_o1, n_o1;
    t_out_item  r_out, n_out;

    logic       w_in_fire;
    logic       w_in_ok;
    t_letter    w_mapped;
    logic [31:0] w_used32;
    logic       w_key_place;
    logic       w_fill_place;
    logic       w_we;
    t_letter    w_wl;
    t_letter    w_pos_raddr;
    t_pos       w_pos_rdata;
    t_pos       w_sq_raddr;
    t_letter    w_sq_rdata;
    t_pos       w_addr1;
    t_pos       w_addr2;
    logic       w_slot;
    logic       w_double;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_in_ok     = (i_in_data.letter <= LETTER_MAX);
    assign w_mapped    = (i_in_data.letter == LETTER_J) ? LETTER_I : i_in_data.letter;
    assign w_used32    = {6'b0, r_used};
    assign w_slot      = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Square placement: key letters in the idle cycle, alphabet during the fill
    assign w_key_place  = w_in_fire && (i_in_data.action == ACT_KEY) && w_in_ok
                          && !r_complete && !w_used32[w_mapped];
    assign w_fill_place = (r_state == S_FILL) && !r_complete
                          && (r_scan != LETTER_J) && !w_used32[r_scan];
    assign w_we = w_key_place || w_fill_place;
    assign w_wl = w_fill_place ? r_scan : w_mapped;

    // Read address muxes; the sequencer never overlaps a write with a read
    assign w_pos_raddr = (r_state == S_RDA) ? r_a : r_b;
    assign w_sq_raddr  = (r_state == S_SQ1) ? r_addr1 : r_addr2;

    pfc_ram #(.WIDTH(5), .DEPTH(CELLS)) u_square (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_fill),
        .i_wdata (w_wl),
        .i_raddr (w_sq_raddr),
        .o_rdata (w_sq_rdata)
    );

    pfc_ram #(.WIDTH(5), .DEPTH(NLETTERS)) u_position (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_wl),
        .i_wdata (r_fill),
        .i_raddr (w_pos_raddr),
        .o_rdata (w_pos_rdata)
    );

    pfc_geom u_geom (
        .i_pos_a (r_pa),
        .i_pos_b (w_pos_rdata),
        .i_dec   (r_dec),
        .o_addr1 (w_addr1),
        .o_addr2 (w_addr2)
    );

    assign w_double = !r_mode && (r_letter == r_held);

    // Sequencer and next-state logic
    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_fill       = r_fill;
        n_complete   = r_complete;
        n_scan       = r_scan;
        n_held_valid = r_held_valid;
        n_held       = r_held;
        n_act        = r_act;
        n_letter     = r_letter;
        n_a          = r_a;
        n_b          = r_b;
        n_dec        = r_dec;
        n_tail       = r_tail;
        n_kind       = r_kind;
        n_pa         = r_pa;
        n_addr1      = r_addr1;
        n_addr2      = r_addr2;
        n_o1         = r_o1;
        n_out        = r_out;
        n_out_valid  = i_out_ready ? 1'b0 : r_out_valid;

        // Book-keeping for a placed letter
        if (w_we) begin
            n_used     = r_used | (NLETTERS'(1) << w_wl);
            n_fill     = r_fill + 5'd1;
            n_complete = (r_fill == 5'(CELLS - 1));
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_act    = i_in_data.action;
                    n_letter = w_mapped;
                    if ((i_in_data.action == ACT_KEY_END)
                        || (i_in_data.action == ACT_MSG_END)
                        || ((i_in_data.action == ACT_MSG) && w_in_ok)) begin
                        n_state = S_FILL;
                    end
                end
            end
            S_FILL: begin
                if (!r_complete) begin
                    n_scan = r_scan + 5'd1;
                end else begin
                    n_state = S_IDLE;
                    if (r_act == ACT_MSG) begin
                        if (!r_held_valid) begin
                            n_held       = r_letter;
                            n_held_valid = 1'b1;
                        end else begin
                            n_a    = r_held;
                            n_dec  = r_mode;
                            n_tail = 1'b0;
                            if (w_double) begin
                                n_b = (r_held == LETTER_X) ? LETTER_Z : LETTER_X;
                            end else begin
                                n_b          = r_letter;
                                n_held_valid = 1'b0;
                            end
                            n_state = S_RDA;
                        end
                    end else if (r_act == ACT_MSG_END) begin
                        n_held_valid = 1'b0;
                        n_kind       = KIND_END;
                        n_state      = S_MARK;
                        if (r_held_valid && !r_mode) begin
                            n_a     = r_held;
                            n_b     = (r_held == LETTER_Z) ? LETTER_X : LETTER_Z;
                            n_dec   = 1'b0;
                            n_tail  = 1'b1;
                            n_state = S_RDA;
                        end else if (r_held_valid) begin
                            n_kind = KIND_END_ODD;
                        end
                    end
                end
            end
            S_RDA:  n_state = S_RDB;
            S_RDB: begin
                n_pa    = w_pos_rdata;
                n_state = S_CALC;
            end
            S_CALC: begin
                n_addr1 = w_addr1;
                n_addr2 = w_addr2;
                n_state = S_SQ1;
            end
            S_SQ1:  n_state = S_SQ2;
            S_SQ2: begin
                n_o1    = w_sq_rdata;
                n_state = S_EMIT1;
            end
            S_EMIT1: begin
                if (w_slot) begin
                    n_out       = '{letter_out: r_o1, kind: KIND_LETTER, last: 1'b0};
                    n_out_valid = 1'b1;
                    n_state     = S_EMIT2;
                end
            end
            S_EMIT2: begin
                if (w_slot) begin
                    n_out       = '{letter_out: w_sq_rdata, kind: KIND_LETTER,
                                    last: !r_tail};
                    n_out_valid = 1'b1;
                    n_state     = r_tail ? S_MARK : S_IDLE;
                end
            end
            S_MARK: begin
                if (w_slot) begin
                    n_out       = '{letter_out: 5'd0, kind: r_kind, last: 1'b1};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= 1'b0;
            r_used       <= '0;
            r_fill       <= '0;
            r_complete   <= 1'b0;
            r_scan       <= '0;
            r_held_valid <= 1'b0;
            r_held       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            r_used       <= n_used;
            r_fill       <= n_fill;
            r_complete   <= n_complete;
            r_scan       <= n_scan;
            r_held_valid <= n_held_valid;
            r_held       <= n_held;
            r_out_valid  <= n_out_valid;
        end
    end

    // Working payload
    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_letter <= n_letter;
        r_a      <= n_a;
        r_b      <= n_b;
        r_dec    <= n_dec;
        r_tail   <= n_tail;
        r_kind   <= n_kind;
        r_pa     <= n_pa;
        r_addr1  <= n_addr1;
        r_addr2  <= n_addr2;
        r_o1     <= n_o1;
        r_out    <= n_out;
    end

    // Checks
    `PFC_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= 5'(CELLS), "fill count overrun")
    `PFC_ASSERT(a_complete_fill, i_clk, i_rst_n, r_complete == (r_fill == 5'(CELLS)), "complete flag out of step with fill count")
    `PFC_ASSERT_IMP(a_pair_needs_square, i_clk, i_rst_n, r_state == S_RDA, r_complete, "pair lookup before square complete")
    `PFC_ASSERT_IMP(a_held_not_j, i_clk, i_rst_n, r_held_valid, r_held != LETTER_J, "j held for pairing")
    `PFC_ASSERT_IMP(a_marker_last, i_clk, i_rst_n, r_out_valid && (r_out.kind != KIND_LETTER), r_out.last && (r_out.letter_out == 5'd0), "end marker malformed")

endmodule
